@@ src/ced_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ced_pkg
// shared types, constants and helpers of the completion edit distance column
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int MAX_LEN = 64;
  localparam int DEPTH   = MAX_LEN + 1;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int SYM_W   = 9;
  localparam int DIST_W  = 8;
  localparam int OP_W    = 2;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 24;

  localparam logic [SYM_W-1:0]  SPACE_RESET = SYM_W'(2 + 26 + 10);
  localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_PROBE   = 2'd2,
    OP_ADVANCE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_APPEND,
    S_RDEND,
    S_START,
    S_LOAD,
    S_STEP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic append;
    logic rd_end;
    logic start;
    logic load;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic len_zero;
    logic full;
    logic last;
    logic out_free;
  } sts_t;

  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v,
                                                input logic add);
    logic [DIST_W:0] s;
    s = {1'b0, v} + {{DIST_W{1'b0}}, add};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] len_to_dist(input logic [IDX_W-1:0] l);
    logic [IDX_W+DIST_W-1:0] w;
    w = {{DIST_W{1'b0}}, l};
    return (w > (IDX_W + DIST_W)'(DIST_MAX)) ? DIST_MAX : w[DIST_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ src/ced_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ced_ctrl
// sequencer: decodes the op and walks the column one row per cycle
// ----------------------------------------------------------------------------
module ced_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire ced_pkg::op_t  in_op,
  output logic               in_ready,
  input  wire ced_pkg::sts_t sts,
  output ced_pkg::cmd_t      cmd
);
  import ced_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_CLEAR:   state_nxt = S_CLEAR;
            OP_APPEND:  state_nxt = S_APPEND;
            OP_PROBE:   state_nxt = S_START;
            OP_ADVANCE: state_nxt = S_START;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR:  state_nxt = S_DONE;
      S_APPEND: state_nxt = sts.full ? S_RDEND : S_DONE;
      S_RDEND:  state_nxt = S_DONE;
      S_START:  state_nxt = S_LOAD;
      S_LOAD:   state_nxt = sts.len_zero ? S_DONE : S_STEP;
      S_STEP:   state_nxt = sts.last ? S_DONE : S_STEP;
      S_DONE:   state_nxt = sts.out_free ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_CLEAR:  cmd.clear    = 1'b1;
      S_APPEND: cmd.append   = 1'b1;
      S_RDEND:  cmd.rd_end   = 1'b1;
      S_START:  cmd.start    = 1'b1;
      S_LOAD:   cmd.load     = 1'b1;
      S_STEP:   cmd.step     = 1'b1;
      S_DONE:   cmd.out_load = sts.out_free;
      default:  cmd          = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/ced_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ced_dp
// pattern and column memories, row update unit and result register
// ----------------------------------------------------------------------------
module ced_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ced_pkg::cmd_t                 cmd,
  output ced_pkg::sts_t                      sts,
  input  wire ced_pkg::op_t                  in_op,
  input  wire logic [ced_pkg::SYM_W-1:0]     in_symbol,
  input  wire logic                          cfg_we,
  input  wire logic [ced_pkg::SYM_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ced_pkg::DIST_W-1:0]         out_end_distance,
  output logic signed [ced_pkg::DIST_W-1:0]  out_change,
  output logic                               out_refused
);
  import ced_pkg::*;

  logic [SYM_W-1:0]  pstore_mem [DEPTH];
  logic [DIST_W-1:0] dcol_mem   [DEPTH];

  op_t               op_r;
  logic [SYM_W-1:0]  sym_r;
  logic [SYM_W-1:0]  space_r;
  logic [IDX_W-1:0]  len_r;
  logic [DIST_W-1:0] pos_r;
  logic [IDX_W-1:0]  j_r;
  logic [SYM_W-1:0]  ps_rd_r;
  logic [DIST_W-1:0] dc_rd_r;
  logic [SYM_W-1:0]  prev_sym_r;
  logic [DIST_W-1:0] prev_old_r;
  logic [DIST_W-1:0] prev_new_r;
  logic [DIST_W-1:0] end_r;
  logic [DIST_W-1:0] old_r;
  logic              refused_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_end_r;
  logic [DIST_W-1:0] out_change_r;
  logic              out_refused_r;

  logic              rd_en;
  logic [IDX_W-1:0]  raddr;
  logic              dc_we;
  logic [IDX_W-1:0]  dc_waddr;
  logic [DIST_W-1:0] dc_wdata;
  logic              ps_we;
  logic              advance;
  logic [IDX_W-1:0]  len_inc;
  logic [IDX_W-1:0]  j_inc;
  logic [SYM_W-1:0]  next_sym;
  logic              free_ins;
  logic              same;
  logic [DIST_W-1:0] ins_cost;
  logic [DIST_W-1:0] sub_cost;
  logic [DIST_W-1:0] del_cost;
  logic [DIST_W-1:0] best;
  logic signed [DIST_W:0]   diff;
  logic signed [DIST_W-1:0] diff_sat;

  assign advance = (op_r == OP_ADVANCE);
  assign len_inc = len_r + IDX_W'(1);
  assign j_inc   = j_r + IDX_W'(1);

  assign sts.len_zero = (len_r == '0);
  assign sts.full     = (len_r == IDX_W'(MAX_LEN));
  assign sts.last     = (j_r == len_r);
  assign sts.out_free = !out_valid_r || out_ready;

  // row update
  always_comb begin
    next_sym = (j_r < len_r) ? ps_rd_r : '0;
    free_ins = (j_r >= len_r) || (next_sym == '0) || (next_sym == space_r);
    same     = (sym_r == prev_sym_r);
    ins_cost = sat_inc(dc_rd_r, !free_ins);
    sub_cost = sat_inc(prev_old_r, !same);
    del_cost = sat_inc(prev_new_r, 1'b1);
    best     = ins_cost;
    if (sub_cost < best) best = sub_cost;
    if (del_cost < best) best = del_cost;
  end

  always_comb begin
    diff = $signed({1'b0, end_r}) - $signed({1'b0, old_r});
    priority if (diff > $signed((DIST_W + 1)'(127))) begin
      diff_sat = DIST_W'(127);
    end else if (diff < -$signed((DIST_W + 1)'(128))) begin
      diff_sat = -$signed(DIST_W'(128));
    end else begin
      diff_sat = diff[DIST_W-1:0];
    end
  end

  // memory address and write selection
  always_comb begin
    rd_en    = 1'b0;
    raddr    = '0;
    dc_we    = 1'b0;
    dc_waddr = '0;
    dc_wdata = '0;
    ps_we    = 1'b0;
    if (cmd.start) begin
      rd_en = 1'b1;
    end
    if (cmd.load) begin
      rd_en    = !sts.len_zero;
      raddr    = IDX_W'(1);
      dc_we    = advance;
      dc_wdata = pos_r;
    end
    if (cmd.step) begin
      rd_en    = !sts.last;
      raddr    = j_inc;
      dc_we    = advance;
      dc_waddr = j_r;
      dc_wdata = best;
    end
    if (cmd.clear) begin
      dc_we = 1'b1;
    end
    if (cmd.append) begin
      rd_en    = sts.full;
      raddr    = len_r;
      ps_we    = !sts.full;
      dc_we    = !sts.full;
      dc_waddr = len_inc;
      dc_wdata = len_to_dist(len_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (ps_we) begin
      pstore_mem[len_r] <= sym_r;
    end
    if (rd_en) begin
      ps_rd_r <= pstore_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (dc_we) begin
      dcol_mem[dc_waddr] <= dc_wdata;
    end
    if (rd_en) begin
      dc_rd_r <= dcol_mem[raddr];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_op;
      sym_r <= in_symbol;
    end
    if (cmd.clear) begin
      end_r     <= '0;
      refused_r <= 1'b0;
    end
    if (cmd.append) begin
      end_r     <= len_to_dist(len_inc);
      refused_r <= sts.full;
    end
    if (cmd.rd_end) begin
      end_r <= dc_rd_r;
    end
    if (cmd.start) begin
      refused_r <= 1'b0;
    end
    if (cmd.load) begin
      prev_sym_r <= ps_rd_r;
      prev_old_r <= dc_rd_r;
      prev_new_r <= pos_r;
      j_r        <= IDX_W'(1);
      if (sts.len_zero) begin
        old_r <= dc_rd_r;
        end_r <= pos_r;
      end
    end
    if (cmd.step) begin
      prev_sym_r <= ps_rd_r;
      prev_old_r <= dc_rd_r;
      prev_new_r <= best;
      j_r        <= j_inc;
      if (sts.last) begin
        old_r <= dc_rd_r;
        end_r <= best;
      end
    end
    if (cmd.out_load) begin
      out_end_r     <= end_r;
      out_refused_r <= refused_r;
      out_change_r  <= (op_r == OP_PROBE || op_r == OP_ADVANCE) ? diff_sat : '0;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_r     <= SPACE_RESET;
      len_r       <= '0;
      pos_r       <= DIST_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        space_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        len_r <= '0;
        pos_r <= DIST_W'(1);
      end
      if (cmd.append && !sts.full) begin
        len_r <= len_inc;
      end
      if (cmd.out_load && advance) begin
        pos_r <= sat_inc(pos_r, 1'b1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_end_distance = out_end_r;
  assign out_change       = out_change_r;
  assign out_refused      = out_refused_r;

`ifndef NO_ASSERTIONS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= IDX_W'(MAX_LEN))
    else $error("pattern length beyond store");

  a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwrites an untaken beat");

  a_step_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (j_r != '0 && j_r <= len_r))
    else $error("row index out of range");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (len_r == '0 && pos_r == DIST_W'(1)))
    else $error("clear did not reset length and position");
`endif

endmodule
`default_nettype wire

@@ src/completion_edit_distance_column_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// completion_edit_distance_column_core
// edit-distance column against a growing completion, with pattern store
// ----------------------------------------------------------------------------
// sequence: clear and append each go through their own state (append also reads
//   the end entry when full); probe and advance go start, load, a step per row, done
// a new item is taken only in idle, once the previous result is in the result
//   register; the column walk reads one row per cycle and, on advance, writes it back
// reset: length 0, position 1, space symbol 38; the memories are not cleared
module completion_edit_distance_column_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [ced_pkg::IN_W-1:0]   in_tdata,   // op, symbol
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [ced_pkg::OUT_W-1:0]       out_tdata,  // end_distance, change, refused
  input  wire logic                       cfg_we,
  input  wire logic [ced_pkg::SYM_W-1:0]  cfg_wdata   // blank code
);
  import ced_pkg::*;

  cmd_t                     cmd;
  sts_t                     sts;
  op_t                      in_op;
  logic [SYM_W-1:0]         in_symbol;
  logic [DIST_W-1:0]        end_distance;
  logic signed [DIST_W-1:0] change;
  logic                     refused;

  assign in_op     = op_t'(in_tdata[OP_W-1:0]);
  assign in_symbol = in_tdata[OP_W +: SYM_W];

  ced_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_op),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ced_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_symbol        (in_symbol),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_end_distance (end_distance),
    .out_change       (change),
    .out_refused      (refused)
  );

  assign out_tdata = {{(OUT_W - 2 * DIST_W - 1){1'b0}}, refused, change, end_distance};

endmodule
`default_nettype wire

@@ sim/tb_completion_edit_distance_column_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_completion_edit_distance_column_core
// checks the edit-distance column core against its own column predictor;
// directed corner cases, then random words (clear, append, probe, advance),
// under several space symbols, with random idling on both stream sides
// ----------------------------------------------------------------------------
module tb_completion_edit_distance_column_core;
  import ced_pkg::*;

  localparam int LIMIT = 1_000_000;

  typedef struct packed {
    logic [DIST_W-1:0] end_dist;
    logic [DIST_W-1:0] change;
    logic              refused;
  } col_result_t;

  class ed_column_scoreboard;
    logic [SYM_W-1:0]  space_sym;
    logic [SYM_W-1:0]  pat [DEPTH];
    logic [DIST_W-1:0] col [DEPTH];
    int unsigned       plen;
    int unsigned       pos;
    col_result_t       due_results [$];
    int                mismatches;

    function new();
      space_sym  = SPACE_RESET;
      plen       = 0;
      pos        = 1;
      mismatches = 0;
    endfunction

    function void set_space(logic [SYM_W-1:0] v);
      space_sym = v;
    endfunction

    function logic [DIST_W-1:0] bump(logic [DIST_W-1:0] v, bit add);
      return (v == DIST_MAX) ? v : v + DIST_W'(add);
    endfunction

    function void note_item(op_t op, logic [SYM_W-1:0] sym);
      logic [DIST_W-1:0] nxt [DEPTH];
      logic [DIST_W-1:0] ins, sub, del, best;
      logic [SYM_W-1:0]  follow;
      bit                free_ins;
      int                diff;
      col_result_t       r;
      r = '0;
      case (op)
        OP_CLEAR: begin
          plen       = 0;
          pos        = 1;
          col[0]     = '0;
          r.end_dist = '0;
        end
        OP_APPEND: begin
          if (plen >= MAX_LEN) begin
            r.refused = 1'b1;
          end else begin
            pat[plen] = sym;
            plen++;
            col[plen] = DIST_W'(plen);
          end
          r.end_dist = col[plen];
        end
        default: begin
          nxt[0] = DIST_W'(pos);
          for (int unsigned j = 1; j <= plen; j++) begin
            follow   = (j < plen) ? pat[j] : '0;
            free_ins = (j >= plen) || (follow == '0) || (follow == space_sym);
            ins  = bump(col[j], !free_ins);
            sub  = bump(col[j-1], sym != pat[j-1]);
            del  = bump(nxt[j-1], 1'b1);
            best = ins;
            if (best > sub) best = sub;
            if (best > del) best = del;
            nxt[j] = best;
          end
          r.end_dist = nxt[plen];
          diff = int'(nxt[plen]) - int'(col[plen]);
          if (diff > 127) diff = 127;
          if (diff < -128) diff = -128;
          r.change = diff[DIST_W-1:0];
          if (op == OP_ADVANCE) begin
            for (int unsigned j = 0; j <= plen; j++) col[j] = nxt[j];
            if (pos < 255) pos++;
          end
        end
      endcase
      due_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      col_result_t got, want;
      got.end_dist = d[7:0];
      got.change   = d[15:8];
      got.refused  = d[16];
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: end %0d change %0d refused %0b",
                   got.end_dist, $signed(got.change), got.refused);
        return;
      end
      want = due_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want end %0d chg %0d ref %0b, got end %0d chg %0d ref %0b",
                   want.end_dist, $signed(want.change), want.refused,
                   got.end_dist, $signed(got.change), got.refused);
      end
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata   = '0;   // op, symbol
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;         // end_distance, change, refused
  logic              cfg_we     = 1'b0;
  logic [SYM_W-1:0]  cfg_wdata  = '0;   // blank code

  ed_column_scoreboard sb = new();
  bit                  no_idle = 1'b0;
  int                  sent = 0;
  int                  cycles = 0;

  completion_edit_distance_column_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: check each accepted beat, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= no_idle || ($urandom_range(0, 99) >= 28);
  end

  task automatic send_item(op_t op, logic [SYM_W-1:0] sym);
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-OP_W-SYM_W){1'b0}}, sym, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(op, sym);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_space(logic [SYM_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_space(v);
  endtask

  function automatic logic [SYM_W-1:0] pattern_symbol();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return SYM_W'($urandom_range(1, 6));
    if (roll < 52) return sb.space_sym;
    if (roll < 60) return '0;
    return SYM_W'($urandom_range(0, 511));
  endfunction

  function automatic logic [SYM_W-1:0] completion_symbol();
    int roll;
    roll = $urandom_range(0, 99);
    if (sb.plen > 0 && roll < 55) return sb.pat[$urandom_range(0, sb.plen - 1)];
    if (roll < 80) return SYM_W'($urandom_range(1, 6));
    return SYM_W'($urandom_range(0, 511));
  endfunction

  // one well-formed word most of the time, otherwise a burst of noise
  task automatic run_word();
    int n;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 6))
        send_item(op_t'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 511)));
      return;
    end
    case ($urandom_range(0, 9))
      0:       n = $urandom_range(60, 70);
      1, 2:    n = $urandom_range(9, 40);
      default: n = $urandom_range(0, 8);
    endcase
    send_item(OP_CLEAR, SYM_W'($urandom_range(0, 511)));
    repeat (n) send_item(OP_APPEND, pattern_symbol());
    repeat ($urandom_range(1, 12))
      send_item(op_t'(($urandom_range(0, 9) < 3) ? OP_PROBE : OP_ADVANCE),
                completion_symbol());
  endtask

  initial begin
    logic [SYM_W-1:0] spaces [5];
    int               phase_start;
    spaces[0] = SPACE_RESET;
    spaces[1] = '0;
    spaces[2] = '1;
    spaces[3] = SYM_W'($urandom_range(0, 511));
    spaces[4] = SYM_W'($urandom_range(1, 6));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners under the reset space symbol
    send_item(OP_CLEAR,   9'd0);
    send_item(OP_PROBE,   9'd5);
    send_item(OP_APPEND,  9'd0);
    send_item(OP_APPEND,  9'd511);
    send_item(OP_APPEND,  9'd38);
    send_item(OP_APPEND,  9'd5);
    send_item(OP_PROBE,   9'd511);
    send_item(OP_PROBE,   9'd0);
    send_item(OP_ADVANCE, 9'd511);
    send_item(OP_ADVANCE, 9'd0);
    send_item(OP_ADVANCE, 9'd38);
    send_item(OP_ADVANCE, 9'd5);
    send_item(OP_PROBE,   9'd7);
    send_item(OP_APPEND,  9'd1);
    send_item(OP_ADVANCE, 9'd1);
    send_item(OP_CLEAR,   9'd511);
    send_item(OP_ADVANCE, 9'd3);
    send_item(OP_APPEND,  9'd38);
    send_item(OP_PROBE,   9'd38);
    send_item(OP_ADVANCE, 9'd100);

    for (int p = 0; p < 5; p++) begin
      drain();
      write_space(spaces[p]);
      no_idle = (p == 2);
      if (p == 1) begin
        // position and distances run into saturation
        send_item(OP_CLEAR,  9'd0);
        send_item(OP_APPEND, 9'd1);
        send_item(OP_APPEND, 9'd2);
        repeat (270) send_item(OP_ADVANCE, SYM_W'($urandom_range(1, 6)));
      end
      phase_start = sent;
      while (sent - phase_start < 100) run_word();
    end
    no_idle = 1'b0;

    drain();
    repeat (70) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ced_pkg.sv
src/ced_ctrl.sv
src/ced_dp.sv
src/completion_edit_distance_column_core.sv
sim/tb_completion_edit_distance_column_core.sv
